// ===== hdl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the sorted insertion stack.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    logic [OPCODE_W-1:0]          opcode;
    logic signed [DATA_WIDTH-1:0] value;
  } item_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] top_value;
    logic [COUNT_W-1:0]           count;
    logic                         empty_res;
    logic [STATUS_W-1:0]          status;
  } result_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                         push;
    logic                         pop;
    logic signed [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/sis_cell.sv =====
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted chain. Cell 0 holds the minimum; values rise
// toward the far end. On push a cell keeps, takes the new value or takes its
// upper neighbor's value; on pop it takes its lower neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell
  import sis_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire cell_cmd_t                    cmd_i,
  input  wire logic                         occ_i,        // slot holds a live entry
  input  wire logic                         prev_lt_i,    // upper neighbor keeps its value
  input  wire logic signed [DATA_WIDTH-1:0] prev_data_i,  // from upper neighbor
  input  wire logic signed [DATA_WIDTH-1:0] next_data_i,  // from lower neighbor
  output      logic                         lt_o,
  output      logic signed [DATA_WIDTH-1:0] data_o
);

  logic signed [DATA_WIDTH-1:0] data_q, data_d;

  // Empty slots compare as larger than anything
  assign lt_o = occ_i && (data_q < cmd_i.value);

  always_comb begin
    data_d = data_q;
    if (cmd_i.push) begin
      if (!lt_o) begin
        data_d = prev_lt_i ? cmd_i.value : prev_data_i;
      end
    end else if (cmd_i.pop) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_insertion_stack.sv =====
// ----------------------------------------------------------------------------
// sorted_insertion_stack
// Bounded stack kept in sorted order with the minimum on top.
//
//   channel  ports                    handshake
//   input    item_i (item_t)          start high while busy low
//   result   result_o (result_t)      done_o high for one cycle
//
// One word per cycle: every cell compares against the pushed value in
// parallel and shifts by one slot, so the whole chain updates together.
// The result appears in the cycle after acceptance, from the updated cells.
// busy stays low; a new word may be taken in the same cycle a result shows.
// Reset (rst_ni low) clears the count, status and strobe; cell contents are
// undefined until written and are never shown while unoccupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_stack
  import sis_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output      logic    busy,
  input  wire item_t   item_i,
  output      logic    done_o,
  output      result_t result_o
);

  logic                         accept;
  logic [COUNT_W-1:0]           count_q, count_d;
  status_e                      status_q, status_d;
  logic                         done_q;
  cell_cmd_t                    cmd;
  logic [DEPTH-1:0]             occ;
  logic [DEPTH-1:0]             lt;
  logic signed [DATA_WIDTH-1:0] data [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    cmd.value = item_i.value;
    count_d   = count_q;
    status_d  = ST_OK;
    if (accept) begin
      case (item_i.opcode)
        OP_PUSH: begin
          if (count_q >= COUNT_W'(DEPTH)) begin
            status_d = ST_PUSH_FULL;
          end else begin
            cmd.push = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        OP_POP: begin
          if (count_q == '0) begin
            status_d = ST_POP_EMPTY;
          end else begin
            cmd.pop = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         prev_lt;
    logic signed [DATA_WIDTH-1:0] prev_data, next_data;

    assign occ[i] = (COUNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_lt   = 1'b1;
      assign prev_data = '0;
    end else begin : g_body
      assign prev_lt   = lt[i-1];
      assign prev_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_link
      assign next_data = data[i+1];
    end

    sis_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[i]),
      .prev_lt_i   (prev_lt),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .lt_o        (lt[i]),
      .data_o      (data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  assign done_o             = done_q;
  assign result_o.top_value = (count_q == '0) ? '0 : data[0];
  assign result_o.count     = count_q;
  assign result_o.empty_res = (count_q == '0);
  assign result_o.status    = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted word produced no result strobe");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_PUSH_FULL) |-> count_q == COUNT_W'(DEPTH))
    else $error("push refused while not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> count_q == $past(count_q))
    else $error("count changed without an accepted word");

endmodule

`default_nettype wire
